FILE: rtl/lcdnw_pkg.sv
package lcdnw_pkg;

  // Request kinds on the input side
  localparam logic [2:0] FUNC_COMMAND = 3'd0;
  localparam logic [2:0] FUNC_CHAR    = 3'd1;
  localparam logic [2:0] FUNC_NIBBLE  = 3'd2;
  localparam logic [2:0] FUNC_CURSOR  = 3'd3;
  localparam logic [2:0] FUNC_NUMBER  = 3'd4;

  // Byte and character codes
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] CHAR_AE_IN    = 8'd228;
  localparam logic [7:0] CHAR_AE_OUT   = 8'd225;
  localparam logic [7:0] CHAR_OE_IN    = 8'd246;
  localparam logic [7:0] CHAR_OE_OUT   = 8'd239;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;

  // Highest decimal position the sequencer can walk (ten digits at most)
  localparam int MAX_DIGIT_POS = 9;
  // Highest position that can hold a nonzero digit of a 16-bit value
  localparam int TOP_VALUE_POS = 4;

  // What the back end has to do with one queued request
  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_NIBBLE,
    KIND_NUMBER
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        rs;
    logic [15:0] data;
  } cmd_t;

  // Weight of decimal position p
  function automatic logic [33:0] pow10(input logic [3:0] p);
    logic [33:0] w;
    unique case (p)
      4'd0:    w = 34'd1;
      4'd1:    w = 34'd10;
      4'd2:    w = 34'd100;
      4'd3:    w = 34'd1000;
      4'd4:    w = 34'd10000;
      4'd5:    w = 34'd100000;
      4'd6:    w = 34'd1000000;
      4'd7:    w = 34'd10000000;
      4'd8:    w = 34'd100000000;
      4'd9:    w = 34'd1000000000;
      default: w = 34'd0;
    endcase
    return w;
  endfunction

  // Digit at position p, for a remainder below ten times that weight
  function automatic logic [3:0] dec_digit(input logic [15:0] r, input logic [3:0] p);
    logic [33:0] w;
    logic [3:0]  d;
    w = pow10(p);
    d = 4'd0;
    for (int m = 1; m <= 9; m++) begin
      if ({18'd0, r} >= 34'(m) * w) d = 4'(m);
    end
    return d;
  endfunction

  // Amount removed from the remainder once digit d at position p is out
  function automatic logic [15:0] dec_weight(input logic [3:0] d, input logic [3:0] p);
    logic [33:0] prod;
    prod = {30'd0, d} * pow10(p);
    return prod[15:0];
  endfunction

endpackage

FILE: rtl/lcdnw_front.sv
module lcdnw_front import lcdnw_pkg::*; (
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // value[15:0]
  input  logic [2:0]  s_tuser,   // func[2:0]
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  // Latin-1 umlauts to display codes
  function automatic logic [7:0] map_char(input logic [7:0] c);
    logic [7:0] m;
    if (c == CHAR_AE_IN)      m = CHAR_AE_OUT;
    else if (c == CHAR_OE_IN) m = CHAR_OE_OUT;
    else                      m = c;
    return m;
  endfunction

  logic known;

  // Unknown kinds are taken and dropped
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full && known;

  // Classify the request
  always_comb begin
    known      = 1'b1;
    q_cmd.kind = KIND_BYTE;
    q_cmd.rs   = 1'b0;
    q_cmd.data = {8'd0, s_tdata[7:0]};
    unique case (s_tuser)
      FUNC_COMMAND: begin
      end
      FUNC_CHAR: begin
        q_cmd.rs   = 1'b1;
        q_cmd.data = {8'd0, map_char(s_tdata[7:0])};
      end
      FUNC_NIBBLE: begin
        q_cmd.kind = KIND_NIBBLE;
      end
      FUNC_CURSOR: begin
        q_cmd.data = {8'd0, CMD_SET_DDRAM | {1'b0, s_tdata[6:0]}};
      end
      FUNC_NUMBER: begin
        q_cmd.kind = KIND_NUMBER;
        q_cmd.rs   = 1'b1;
        q_cmd.data = s_tdata;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/lcdnw_queue.sv
module lcdnw_queue import lcdnw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_cmd
);

  // Two-entry request queue
  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_cmd   = slot[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      if (do_push && !do_pop)      count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

endmodule

FILE: rtl/lcdnw_back.sv
module lcdnw_back import lcdnw_pkg::*; #(
  parameter int NUM_DIGITS = 5
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // bus_nibble[3:0], zero pad[7:4]
  output logic [1:0] m_tuser,   // reg_select[0], long_settle[1]
  output logic       m_tlast    // last
);

  // Start above the shown digits when they do not cover a 16-bit value
  localparam int         START_POS = (NUM_DIGITS - 1 > TOP_VALUE_POS) ?
                                     NUM_DIGITS - 1 : TOP_VALUE_POS;
  localparam logic [3:0] POS_START = 4'(START_POS);
  localparam logic [3:0] POS_SHOWN = 4'(NUM_DIGITS);

  logic        busy, busy_next;
  logic        phase, phase_next;
  kind_t       kind;
  logic        rs;
  logic [15:0] data, data_next;
  logic [3:0]  pos, pos_next;
  logic        seen, seen_next;
  logic [3:0]  ch_lo, ch_lo_next;

  logic        advance;
  logic        emit;
  logic        done;
  logic [3:0]  o_nib;
  logic        o_settle;
  logic        o_last;
  logic [3:0]  digit;
  logic [7:0]  ch;
  logic        shown;
  logic        load;

  assign advance = !m_tvalid || m_tready;
  assign digit   = dec_digit(data, pos);
  assign shown   = (pos < POS_SHOWN);

  // Leading zeros blank, units digit always shown
  always_comb begin
    if (digit != 4'd0 || pos == 4'd0) ch = CHAR_ZERO + {4'd0, digit};
    else if (seen)                     ch = CHAR_ZERO;
    else                               ch = CHAR_SPACE;
  end

  // Strobe sequencing
  always_comb begin
    emit       = 1'b0;
    done       = 1'b0;
    o_nib      = data[7:4];
    o_settle   = 1'b0;
    o_last     = 1'b0;
    phase_next = phase;
    data_next  = data;
    pos_next   = pos;
    seen_next  = seen;
    ch_lo_next = ch_lo;
    if (busy && advance) begin
      unique case (kind)
        KIND_BYTE: begin
          emit = 1'b1;
          if (!phase) begin
            phase_next = 1'b1;
          end else begin
            o_nib      = data[3:0];
            o_settle   = 1'b1;
            o_last     = 1'b1;
            phase_next = 1'b0;
            done       = 1'b1;
          end
        end
        KIND_NIBBLE: begin
          emit     = 1'b1;
          o_settle = 1'b1;
          o_last   = 1'b1;
          done     = 1'b1;
        end
        KIND_NUMBER: begin
          if (!phase) begin
            data_next = data - dec_weight(digit, pos);
            if (shown) begin
              emit       = 1'b1;
              o_nib      = ch[7:4];
              ch_lo_next = ch[3:0];
              seen_next  = seen || (digit != 4'd0);
              phase_next = 1'b1;
            end else begin
              // dropped high digit: no strobe
              pos_next = pos - 4'd1;
            end
          end else begin
            emit       = 1'b1;
            o_nib      = ch_lo;
            o_settle   = 1'b1;
            o_last     = (pos == 4'd0);
            phase_next = 1'b0;
            if (pos == 4'd0) done = 1'b1;
            else             pos_next = pos - 4'd1;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  // Take the next request on the cycle the current one finishes
  assign load      = q_valid && (!busy || done);
  assign q_pop     = load;
  assign busy_next = load ? 1'b1 : (done ? 1'b0 : busy);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else begin
      busy  <= busy_next;
      phase <= load ? 1'b0 : phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind <= q_cmd.kind;
      rs   <= q_cmd.rs;
      data <= q_cmd.data;
      pos  <= POS_START;
      seen <= 1'b0;
    end else begin
      data <= data_next;
      pos  <= pos_next;
      seen <= seen_next;
    end
    ch_lo <= ch_lo_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      m_tdata <= {4'd0, o_nib};
      m_tuser <= {o_settle, rs};
      m_tlast <= o_last;
    end
  end

endmodule

FILE: rtl/char_lcd_nibble_write_sequencer.sv
// The first strobe of a request passes the queue, the back end's request registers and the output register.
// One strobe per cycle while the receiver is ready; command, character and cursor requests give
// two strobes, a high-nibble request one, a number two per shown digit, plus a silent step per dropped high digit.
// The strobe generator paces everything; a 2-entry queue lets requests arrive meanwhile.
// Reset (rst, synchronous, active high) empties the queue and the output register.
module char_lcd_nibble_write_sequencer import lcdnw_pkg::*; #(
  parameter int NUM_DIGITS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // value[15:0]
  input  logic [2:0]  s_tuser,   // func[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // bus_nibble[3:0], zero pad[7:4]
  output logic [1:0]  m_tuser,   // reg_select[0], long_settle[1]
  output logic        m_tlast    // last
);

  logic q_full;
  logic q_push;
  cmd_t push_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t pop_cmd;

  lcdnw_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  lcdnw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (pop_cmd)
  );

  lcdnw_back #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: rtl/lcdnw_checker.sv
module lcdnw_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser,
  input logic       m_tlast
);

  // Stalled strobe stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("strobe dropped while stalled");

  // Stalled strobe keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("strobe payload changed while stalled");

  // A request never ends on a short-settle strobe
  a_last_settle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[1])
    else $error("final strobe without long settle");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("strobe valid after reset");

  // Empty queue after reset takes requests
  a_reset_ready: assert property (@(posedge clk)
    rst |=> s_tready)
    else $error("input not ready after reset");

endmodule

bind char_lcd_nibble_write_sequencer lcdnw_checker u_lcdnw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

FILE: test/lcd_strobe_checker.sv
module lcd_strobe_checker import lcdnw_pkg::*; #(
  parameter int NUM_DIGITS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // value[15:0]
  input  logic [2:0]  s_tuser,   // func[2:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // bus_nibble[3:0], zero pad[7:4]
  input  logic [1:0]  m_tuser,   // reg_select[0], long_settle[1]
  input  logic        m_tlast,
  output int          errors,
  output int          pending
);

  // One strobe on the display bus
  typedef struct packed {
    logic       rs;
    logic [3:0] nibble;
    logic       settle;
    logic       is_last;
  } strobe_t;

  strobe_t strobe_q[$];
  int      mismatches = 0;
  int      owed = 0;

  assign errors  = mismatches;
  assign pending = owed;

  // Latin-1 umlauts to display codes
  function automatic logic [7:0] lcd_code(input logic [7:0] c);
    if (c == CHAR_AE_IN) return CHAR_AE_OUT;
    if (c == CHAR_OE_IN) return CHAR_OE_OUT;
    return c;
  endfunction

  // A byte goes high nibble first; only the low nibble gets the long settle
  task automatic queue_byte(input logic rs, input logic [7:0] b, input logic is_last);
    strobe_q.push_back(strobe_t'{rs, b[7:4], 1'b0, 1'b0});
    strobe_q.push_back(strobe_t'{rs, b[3:0], 1'b1, is_last});
  endtask

  // Decimal number: leading zero digits become spaces, units digit always shown
  task automatic queue_number(input logic [15:0] value);
    int unsigned weight;
    int unsigned digit;
    bit          seen;
    logic [7:0]  ch;
    weight = 1;
    seen   = 1'b0;
    for (int i = 1; i < NUM_DIGITS; i++) weight = weight * 10;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      digit = (int'(value) / weight) % 10;
      if (digit != 0 || i == NUM_DIGITS - 1) begin
        ch   = CHAR_ZERO + 8'(digit);
        seen = 1'b1;
      end else begin
        ch = seen ? CHAR_ZERO : CHAR_SPACE;
      end
      queue_byte(1'b1, lcd_code(ch), i == NUM_DIGITS - 1);
      weight = weight / 10;
      if (weight == 0) weight = 1;
    end
  endtask

  // Strobe burst for one request; unused kinds give nothing
  task automatic queue_request(input logic [2:0] func, input logic [15:0] value);
    case (func)
      FUNC_COMMAND: queue_byte(1'b0, value[7:0], 1'b1);
      FUNC_CHAR:    queue_byte(1'b1, lcd_code(value[7:0]), 1'b1);
      FUNC_NIBBLE:  strobe_q.push_back(strobe_t'{1'b0, value[7:4], 1'b1, 1'b1});
      FUNC_CURSOR:  queue_byte(1'b0, CMD_SET_DDRAM + {1'b0, value[6:0]}, 1'b1);
      FUNC_NUMBER:  queue_number(value);
      default: ;
    endcase
  endtask

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Requests in first, then strobes out
  always @(posedge clk) begin
    strobe_t want;
    strobe_t got;
    if (rst) begin
      strobe_q.delete();
    end else begin
      if (s_tvalid && s_tready) queue_request(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        got = strobe_t'{m_tuser[0], m_tdata[3:0], m_tuser[1], m_tlast};
        if (strobe_q.size() == 0) begin
          flag($sformatf("unexpected strobe rs=%0d nib=%h settle=%0d last=%0d",
                         got.rs, got.nibble, got.settle, got.is_last));
        end else begin
          want = strobe_q.pop_front();
          if (got !== want || m_tdata[7:4] !== 4'd0)
            flag($sformatf({"strobe mismatch: expected rs=%0d nib=%h settle=%0d last=%0d,",
                            " got rs=%0d nib=%h settle=%0d last=%0d pad=%h"},
                           want.rs, want.nibble, want.settle, want.is_last,
                           got.rs, got.nibble, got.settle, got.is_last, m_tdata[7:4]));
        end
      end
    end
    owed <= strobe_q.size();
  end

endmodule

FILE: test/char_lcd_nibble_write_sequencer_tb.sv
module char_lcd_nibble_write_sequencer_tb;
  import lcdnw_pkg::*;

  localparam int NUM_DIGITS    = 5;
  localparam int RAND_REQUESTS = 400;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // value[15:0]
  logic [2:0]  s_tuser = '0;   // func[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // bus_nibble[3:0], zero pad[7:4]
  logic [1:0]  m_tuser;        // reg_select[0], long_settle[1]
  logic        m_tlast;

  int strobe_errors;
  int strobes_owed;
  int cycles = 0;
  bit rx_hold = 1'b0;

  always #4 clk = ~clk;

  char_lcd_nibble_write_sequencer #(.NUM_DIGITS(NUM_DIGITS)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  lcd_strobe_checker #(.NUM_DIGITS(NUM_DIGITS)) i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast), .errors(strobe_errors), .pending(strobes_owed)
  );

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d strobes still owed", cycles, strobes_owed);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: mostly ready, short and long stalls, one long hold on request
  initial begin : rx_side
    int r;
    repeat (10) @(posedge clk);
    forever begin
      if (rx_hold) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          m_tready <= 1'b1;
          repeat ($urandom_range(30, 80)) @(posedge clk);
        end else if (r < 60) begin
          m_tready <= 1'b1;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else if (r < 93) begin
          m_tready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          m_tready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  // Offer one request after an optional gap and wait until it is taken
  task automatic offer(input logic [2:0] f, input logic [15:0] v, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop sending until every predicted strobe has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (strobes_owed != 0) @(posedge clk);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random request, weighted toward umlauts and short numbers
  function automatic void pick_request(output logic [2:0] f, output logic [15:0] v);
    int r;
    r = $urandom_range(0, 99);
    v = 16'($urandom);
    if (r < 6) begin
      f = 3'($urandom_range(5, 7));
    end else begin
      f = 3'($urandom_range(0, 4));
      r = $urandom_range(0, 99);
      if (f == FUNC_CHAR && r < 20) begin
        v[7:0] = r[0] ? CHAR_AE_IN : CHAR_OE_IN;
      end else if (f == FUNC_NUMBER) begin
        if (r < 30) v = 16'($urandom_range(0, 999));
        else if (r < 50) v = 16'($urandom_range(0, 6) * (10 ** $urandom_range(0, 4)));
        else if (r < 55) v = 16'hFFFF;
      end
    end
  endfunction

  initial begin : tx_side
    logic [2:0]  f;
    logic [15:0] v;
    int          n;
    int          gap;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every kind, umlaut mapping, ignored kinds
    offer(FUNC_COMMAND, 16'h0000, 0);
    offer(FUNC_COMMAND, 16'hFFFF, 0);
    offer(FUNC_COMMAND, 16'h5AA5, 2);
    offer(FUNC_CHAR,    16'd228,  0);
    offer(FUNC_CHAR,    16'd246,  0);
    offer(FUNC_CHAR,    16'h12E4, 1);
    offer(FUNC_CHAR,    16'h0041, 0);
    offer(FUNC_CHAR,    16'hFFFF, 0);
    offer(FUNC_NIBBLE,  16'h00F0, 0);
    offer(FUNC_NIBBLE,  16'hFF0F, 3);
    offer(FUNC_CURSOR,  16'h0000, 0);
    offer(FUNC_CURSOR,  16'h007F, 0);
    offer(FUNC_CURSOR,  16'hFF80, 0);
    offer(FUNC_NUMBER,  16'd0,    0);
    offer(FUNC_NUMBER,  16'd7,    0);
    offer(FUNC_NUMBER,  16'd10,   1);
    offer(FUNC_NUMBER,  16'd100,  0);
    offer(FUNC_NUMBER,  16'd1000, 0);
    offer(FUNC_NUMBER,  16'd10000, 0);
    offer(FUNC_NUMBER,  16'd40005, 0);
    offer(FUNC_NUMBER,  16'd65535, 0);
    offer(3'd5,         16'hFFFF, 0);
    offer(3'd6,         16'h1234, 0);
    offer(3'd7,         16'h0000, 0);
    offer(FUNC_CHAR,    16'h0020, 0);
    drain();

    // Random traffic; a receiver hold with back-to-back requests, and one pause
    n = 0;
    while (n < RAND_REQUESTS) begin
      pick_request(f, v);
      gap = (rx_hold || (n % 64) < 16) ? 0 : pick_gap();
      offer(f, v, gap);
      if (f <= FUNC_NUMBER) begin
        n++;
        if (n == 100) rx_hold = 1'b1;
        if (n == 250) drain();
      end
    end
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (strobe_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
